// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset.
`define HPFM_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
		else $error("hpfm assertion failed");

// Next-cycle implication under reset.
`define HPFM_ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
		else $error("hpfm assertion failed");

`endif

// ===== design/hpfm_pkg.sv =====
// Package of fixed field widths, result kinds and control types of the hot page marker.
package hpfm_pkg;

	localparam int PAGE_W  = 16;
	localparam int VALUE_W = 17;
	localparam int TOTAL_W = 16;
	localparam int THR_W   = 16;

	localparam logic KIND_COUNT = 1'b0;
	localparam logic KIND_ENTRY = 1'b1;

	typedef struct packed {
		logic clear;
		logic insert;
		logic pop;
	} sort_ctrl_t;

endpackage

// ===== design/hpfm_if.sv =====
// Request and result channel interfaces of the hot page marker.
interface hpfm_in_if;
	logic                       valid;
	logic                       ready;
	logic [hpfm_pkg::PAGE_W-1:0] page_frame;
	logic                       window_end;

	modport source (output valid, output page_frame, output window_end, input ready);
	modport sink (input valid, input page_frame, input window_end, output ready);
endinterface

interface hpfm_out_if;
	logic                         valid;
	logic                         ready;
	logic                         result_kind;
	logic [hpfm_pkg::VALUE_W-1:0] result_value;
	logic [hpfm_pkg::TOTAL_W-1:0] access_total;
	logic                         list_overflow;
	logic                         final_result;

	modport source (output valid, output result_kind, output result_value,
		output access_total, output list_overflow, output final_result, input ready);
	modport sink (input valid, input result_kind, input result_value,
		input access_total, input list_overflow, input final_result, output ready);
	modport mon (input valid, input ready, input result_kind, input result_value,
		input access_total, input list_overflow, input final_result);
endinterface

// ===== design/hpfm_cnt_mem.sv =====
// Synchronous page counter memory with one write and one read port.
module hpfm_cnt_mem #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/hpfm_sort_list.sv =====
// Row of insertion cells that keeps hot pages ordered by descending count.
module hpfm_sort_list #(
	parameter int MAX_HOT    = 63,
	parameter int COUNT_BITS = 16,
	parameter int AW         = 16,
	parameter int UB         = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hpfm_pkg::sort_ctrl_t  ctrl,
	input  logic [AW-1:0]         ins_page,
	input  logic [COUNT_BITS-1:0] ins_count,
	output logic [AW-1:0]         head_page,
	output logic [COUNT_BITS-1:0] head_count,
	output logic [UB-1:0]         used
);

	logic [AW-1:0]         page_q  [MAX_HOT];
	logic [COUNT_BITS-1:0] count_q [MAX_HOT];
	logic [MAX_HOT-1:0]    keep;
	logic [UB-1:0]         used_q;

	for (genvar i = 0; i < MAX_HOT; i++) begin : g_cell
		localparam logic [UB-1:0] IDX = UB'(i);

		assign keep[i] = (IDX < used_q) && (count_q[i] >= ins_count);

		always_ff @(posedge clk) begin
			if (ctrl.insert && !keep[i]) begin
				if (i == 0) begin
					page_q[i]  <= ins_page;
					count_q[i] <= ins_count;
				end else if (keep[(i > 0) ? i - 1 : 0]) begin
					page_q[i]  <= ins_page;
					count_q[i] <= ins_count;
				end else begin
					page_q[i]  <= page_q[(i > 0) ? i - 1 : 0];
					count_q[i] <= count_q[(i > 0) ? i - 1 : 0];
				end
			end else if (ctrl.pop && (i < MAX_HOT - 1)) begin
				page_q[i]  <= page_q[(i < MAX_HOT - 1) ? i + 1 : i];
				count_q[i] <= count_q[(i < MAX_HOT - 1) ? i + 1 : i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (ctrl.clear) begin
			used_q <= '0;
		end else if (ctrl.insert && (used_q < UB'(MAX_HOT))) begin
			used_q <= used_q + UB'(1);
		end else if (ctrl.pop && (used_q != '0)) begin
			used_q <= used_q - UB'(1);
		end
	end

	assign head_page  = page_q[0];
	assign head_count = count_q[0];
	assign used       = used_q;

endmodule

// ===== design/hot_page_frequency_marker_core.sv =====
// Top level of the hot page marker: counter update, window scan and result emission.
//
// One access request is taken per cycle while a window is open; each in-range request
// updates its page counter in the counter memory by a read-modify-write with forwarding
// of the previous write. The request that closes the window starts a scan of all
// PAGE_COUNT counters, one per cycle, which also clears them; no request is taken during
// the scan. Results then leave at up to one per cycle: the count result first, then the
// hot pages. After reset a clearing pass over all counters runs before the first request
// is taken; the threshold register may be written at any idle time.
module hot_page_frequency_marker_core #(
	parameter int PAGE_COUNT = 65536,
	parameter int MAX_HOT    = 63,
	parameter int COUNT_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [hpfm_pkg::THR_W-1:0] cfg_wdata,
	hpfm_in_if.sink                    req,
	hpfm_out_if.source                 res
);

	localparam int AW = $clog2(PAGE_COUNT);
	localparam int UB = $clog2(MAX_HOT + 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(PAGE_COUNT - 1);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [hpfm_pkg::VALUE_W-1:0] HOT_LIMIT = hpfm_pkg::VALUE_W'(MAX_HOT);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_RUN,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	state_t                       state_q;
	logic [AW-1:0]                ptr_q;
	logic [hpfm_pkg::THR_W-1:0]   thr_q;
	logic                         cnt_v_s1;
	logic                         cnt_ok_s1;
	logic                         cnt_last_s1;
	logic [AW-1:0]                cnt_addr_s1;
	logic                         fwd_v_q;
	logic [AW-1:0]                fwd_addr_q;
	logic [COUNT_BITS-1:0]        fwd_val_q;
	logic                         scan_v_s1;
	logic [AW-1:0]                scan_addr_s1;
	logic [hpfm_pkg::VALUE_W-1:0] hot_total_q;
	logic                         emit_first_q;
	logic                         out_v_q;
	logic                         kind_q;
	logic [hpfm_pkg::VALUE_W-1:0] value_q;
	logic [hpfm_pkg::TOTAL_W-1:0] total_q;
	logic                         ovf_q;
	logic                         fin_q;

	logic                         accept;
	logic                         page_ok;
	logic                         mem_we;
	logic [AW-1:0]                mem_waddr;
	logic [COUNT_BITS-1:0]        mem_wdata;
	logic [AW-1:0]                mem_raddr;
	logic [COUNT_BITS-1:0]        mem_rdata;
	logic [COUNT_BITS-1:0]        cur_cnt;
	logic [COUNT_BITS-1:0]        inc_cnt;
	logic                         hot;
	logic                         load;
	logic                         ovf;
	logic [hpfm_pkg::TOTAL_W-1:0] head_total;
	hpfm_pkg::sort_ctrl_t         sort_ctrl;
	logic [AW-1:0]                head_page;
	logic [COUNT_BITS-1:0]        head_count;
	logic [UB-1:0]                used;

	assign req.ready = (state_q == ST_RUN) && !(cnt_v_s1 && cnt_last_s1);
	assign accept    = req.valid && req.ready;
	assign page_ok   = 17'(req.page_frame) < 17'(PAGE_COUNT);

	assign cur_cnt = (fwd_v_q && (fwd_addr_q == cnt_addr_s1)) ? fwd_val_q : mem_rdata;
	assign inc_cnt = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + COUNT_BITS'(1);

	always_comb begin
		mem_raddr = ptr_q;
		mem_waddr = ptr_q;
		mem_wdata = '0;
		mem_we    = 1'b0;
		case (state_q)
			ST_CLEAR, ST_SCAN: begin
				mem_we = 1'b1;
			end
			ST_RUN: begin
				mem_raddr = req.page_frame[AW-1:0];
				mem_waddr = cnt_addr_s1;
				mem_wdata = inc_cnt;
				mem_we    = cnt_v_s1 && cnt_ok_s1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	hpfm_cnt_mem #(
		.DEPTH (PAGE_COUNT),
		.AW    (AW),
		.DW    (COUNT_BITS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign hot = scan_v_s1 && (mem_rdata != '0) && (33'(mem_rdata) >= 33'(thr_q));
	assign load = (state_q == ST_EMIT) && (!out_v_q || res.ready);
	assign ovf  = hot_total_q > HOT_LIMIT;
	assign head_total = (33'(head_count) > 33'(16'hFFFF)) ? 16'hFFFF
		: hpfm_pkg::TOTAL_W'(head_count);

	assign sort_ctrl.clear  = (state_q == ST_RUN) && cnt_v_s1 && cnt_last_s1;
	assign sort_ctrl.insert = hot;
	assign sort_ctrl.pop    = load && !emit_first_q;

	hpfm_sort_list #(
		.MAX_HOT    (MAX_HOT),
		.COUNT_BITS (COUNT_BITS),
		.AW         (AW),
		.UB         (UB)
	) u_sort (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (sort_ctrl),
		.ins_page   (scan_addr_s1),
		.ins_count  (mem_rdata),
		.head_page  (head_page),
		.head_count (head_count),
		.used       (used)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			ptr_q        <= '0;
			thr_q        <= hpfm_pkg::THR_W'(2);
			cnt_v_s1     <= 1'b0;
			fwd_v_q      <= 1'b0;
			scan_v_s1    <= 1'b0;
			hot_total_q  <= '0;
			emit_first_q <= 1'b0;
			out_v_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			cnt_v_s1  <= accept;
			fwd_v_q   <= (state_q == ST_RUN) && mem_we;
			scan_v_s1 <= (state_q == ST_SCAN);
			if (hot) begin
				hot_total_q <= hot_total_q + hpfm_pkg::VALUE_W'(1);
			end
			if (out_v_q && res.ready && !load) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					ptr_q <= ptr_q + AW'(1);
					if (ptr_q == LAST_ADDR) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					ptr_q <= '0;
					if (cnt_v_s1 && cnt_last_s1) begin
						hot_total_q <= '0;
						state_q     <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					ptr_q <= ptr_q + AW'(1);
					if (ptr_q == LAST_ADDR) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					emit_first_q <= 1'b1;
					state_q      <= ST_EMIT;
				end
				ST_EMIT: begin
					if (load) begin
						out_v_q      <= 1'b1;
						emit_first_q <= 1'b0;
						ovf_q        <= ovf;
						if (emit_first_q) begin
							kind_q  <= hpfm_pkg::KIND_COUNT;
							value_q <= hot_total_q;
							total_q <= '0;
							fin_q   <= (used == '0);
							if (used == '0) begin
								state_q <= ST_RUN;
							end
						end else begin
							kind_q  <= hpfm_pkg::KIND_ENTRY;
							value_q <= hpfm_pkg::VALUE_W'(head_page);
							total_q <= head_total;
							fin_q   <= (used == UB'(1));
							if (used == UB'(1)) begin
								state_q <= ST_RUN;
							end
						end
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cnt_ok_s1    <= page_ok;
		cnt_last_s1  <= req.window_end;
		cnt_addr_s1  <= req.page_frame[AW-1:0];
		fwd_addr_q   <= cnt_addr_s1;
		fwd_val_q    <= inc_cnt;
		scan_addr_s1 <= ptr_q;
	end

	assign res.valid         = out_v_q;
	assign res.result_kind   = kind_q;
	assign res.result_value  = value_q;
	assign res.access_total  = total_q;
	assign res.list_overflow = ovf_q;
	assign res.final_result  = fin_q;

endmodule

// ===== design/hpfm_checker.sv =====
// Port checker of the hot page marker result channel, bound to the top level.
`include "assert_macros.svh"

module hpfm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         valid,
	input logic                         ready,
	input logic                         kind,
	input logic [hpfm_pkg::VALUE_W-1:0] value,
	input logic [hpfm_pkg::TOTAL_W-1:0] total,
	input logic                         fin
);

	`HPFM_ASSERT_NXT(a_hold, clk, arst_n, valid && !ready, valid && $stable(value) && $stable(fin))
	`HPFM_ASSERT_IMP(a_count_total, clk, arst_n, valid && (kind == hpfm_pkg::KIND_COUNT), total == '0)
	`HPFM_ASSERT_IMP(a_entry_total, clk, arst_n, valid && (kind == hpfm_pkg::KIND_ENTRY), total != '0)
	`HPFM_ASSERT_IMP(a_empty_window, clk, arst_n, valid && !kind && fin, value == '0)

endmodule

bind hot_page_frequency_marker_core hpfm_checker u_hpfm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.valid  (res.valid),
	.ready  (res.ready),
	.kind   (res.result_kind),
	.value  (res.result_value),
	.total  (res.access_total),
	.fin    (res.final_result)
);
